>>> sv/jmsw_pkg.sv
// Package for the JPEG marker segment walker: phase and event codes, tag constants, tag check.
package jmsw_pkg;

  // Walk phases
  typedef enum logic [2:0] {
    PH_SOI_FIRST   = 3'd0,
    PH_SOI_SECOND  = 3'd1,
    PH_PAIR_FIRST  = 3'd2,
    PH_PAIR_SECOND = 3'd3,
    PH_LEN_HIGH    = 3'd4,
    PH_LEN_LOW     = 3'd5,
    PH_SKIP        = 3'd6,
    PH_STOPPED     = 3'd7
  } phase_t;

  // Result event codes
  typedef enum logic [2:0] {
    EV_BUSY     = 3'd0,
    EV_START_OK = 3'd1,
    EV_NOT_JPEG = 3'd2,
    EV_SEGMENT  = 3'd3,
    EV_STOPPED  = 3'd4,
    EV_BAD_LEN  = 3'd5,
    EV_IGNORED  = 3'd6
  } event_t;

  // Marker bytes
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] TAG_SOI     = 8'hD8;
  localparam logic [7:0] TAG_EOI     = 8'hD9;
  localparam logic [7:0] TAG_APP_LO  = 8'hE0;
  localparam logic [7:0] TAG_APP_HI  = 8'hEF;
  localparam logic [7:0] TAG_DQT     = 8'hDB;
  localparam logic [7:0] TAG_SOF0    = 8'hC0;
  localparam logic [7:0] TAG_DHT     = 8'hC4;
  localparam logic [7:0] TAG_SOS     = 8'hDA;

  localparam int unsigned OUT_BYTES  = 6;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic [15:0] segment_length;
    logic [7:0]  pair_second;
    logic [7:0]  pair_first;
    logic [7:0]  marker_code;
    event_t      event_res;
  } result_t;

  // True for a tag that opens a segment with a length field
  function automatic logic known_tag(input logic [7:0] t);
    logic hit;
    hit = (t == TAG_SOI) || (t == TAG_EOI) || (t == TAG_DQT) ||
          (t == TAG_SOF0) || (t == TAG_DHT) || (t == TAG_SOS) ||
          ((t >= TAG_APP_LO) && (t <= TAG_APP_HI));
    return hit;
  endfunction

endpackage

>>> sv/jpeg_marker_segment_walker.sv
// Top level: walks JPEG marker segments one byte per transfer, one result per byte.
//
//  channel | dir | tdata                      | tuser          | rate
//  s_*     | in  | [7:0] data_byte            | start_of_file  | 1 byte / cycle
//  m_*     | out | event, tag, pair, length   | -              | 1 result / cycle
//
// Each accepted byte is decoded against the walk state in the same cycle and its
// result is loaded into the output register, one byte per cycle sustained while
// m_tready stays high. The output register is the only stage; a byte is taken whenever
// that register is empty or is being drained in the same cycle.
// Reset returns the walk to expect the first start byte and empties the output.
// A stall on m_tready holds the result and deasserts s_tready until it drains.
module jpeg_marker_segment_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] event_res, [10:3] marker_code, [18:11] pair_first,
  // [26:19] pair_second, [42:27] segment_length, [47:43] zero
  output logic [8*jmsw_pkg::OUT_BYTES-1:0] m_tdata
);
  import jmsw_pkg::*;

  localparam int unsigned PadBits = 8 * OUT_BYTES - $bits(result_t);

  phase_t      phase, phase_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [7:0]  current_tag, current_tag_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] skip_count, skip_count_next;
  result_t     result, result_next;
  logic        accept;
  phase_t      phase_eff;
  logic [15:0] full_len;
  logic [15:0] skip_dec;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{PadBits{1'b0}}, result};
  assign full_len = {length_high, s_tdata};
  assign skip_dec = (skip_count != 16'd0) ? (skip_count - 16'd1) : skip_count;

  // Walk state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SOI_FIRST;
      held_byte   <= 8'd0;
      current_tag <= 8'd0;
      length_high <= 8'd0;
      skip_count  <= 16'd0;
    end else if (accept) begin
      phase       <= phase_next;
      held_byte   <= held_byte_next;
      current_tag <= current_tag_next;
      length_high <= length_high_next;
      skip_count  <= skip_count_next;
    end
  end

  // Decode one byte against the walk state
  always_comb begin
    phase_eff        = s_tuser ? PH_SOI_FIRST : phase;
    phase_next       = phase_eff;
    held_byte_next   = held_byte;
    current_tag_next = current_tag;
    length_high_next = length_high;
    skip_count_next  = skip_count;
    result_next      = '0;
    result_next.event_res = EV_BUSY;
    unique case (phase_eff)
      PH_SOI_FIRST: begin
        held_byte_next = s_tdata;
        phase_next     = PH_SOI_SECOND;
      end
      PH_SOI_SECOND: begin
        if (held_byte == MARK_PREFIX && s_tdata == TAG_SOI) begin
          result_next.event_res = EV_START_OK;
          phase_next            = PH_PAIR_FIRST;
        end else begin
          result_next.event_res   = EV_NOT_JPEG;
          result_next.pair_first  = held_byte;
          result_next.pair_second = s_tdata;
          phase_next              = PH_STOPPED;
        end
      end
      PH_PAIR_FIRST: begin
        held_byte_next = s_tdata;
        phase_next     = PH_PAIR_SECOND;
      end
      PH_PAIR_SECOND: begin
        if (held_byte == MARK_PREFIX && known_tag(s_tdata)) begin
          current_tag_next = s_tdata;
          phase_next       = PH_LEN_HIGH;
        end else begin
          result_next.event_res   = EV_STOPPED;
          result_next.pair_first  = held_byte;
          result_next.pair_second = s_tdata;
          phase_next              = PH_STOPPED;
        end
      end
      PH_LEN_HIGH: begin
        length_high_next = s_tdata;
        phase_next       = PH_LEN_LOW;
      end
      PH_LEN_LOW: begin
        result_next.marker_code = current_tag;
        if (full_len < 16'd2) begin
          result_next.event_res = EV_BAD_LEN;
          phase_next            = PH_STOPPED;
        end else begin
          result_next.event_res      = EV_SEGMENT;
          result_next.segment_length = full_len - 16'd2;
          skip_count_next            = full_len - 16'd2;
          phase_next = (full_len == 16'd2) ? PH_PAIR_FIRST : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_next = PH_PAIR_FIRST;
        end
      end
      PH_STOPPED: begin
        result_next.event_res = EV_IGNORED;
      end
      default: begin
        result_next.event_res = EV_IGNORED;
        phase_next            = PH_STOPPED;
      end
    endcase
  end

  // Output register: load on transfer in, drop on transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // A skip phase always has bytes left to skip
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_count != 16'd0)
    else $error("skip phase with zero count");

  // An accepted byte always leaves a result waiting
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted byte produced no result");

  // A start mark always restarts at the second start byte
  a_start_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> phase == PH_SOI_SECOND)
    else $error("start of file did not restart the walk");

  // Tag field is only set for segment and bad length results
  a_tag_only_seg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.event_res != EV_SEGMENT && result.event_res != EV_BAD_LEN)
      |-> result.marker_code == 8'd0)
    else $error("tag reported with wrong event");

  // Length field is only set for segment results
  a_len_only_seg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.event_res != EV_SEGMENT) |-> result.segment_length == 16'd0)
    else $error("length reported with wrong event");

endmodule

>>> verif/tb_top.sv
// Testbench for the JPEG marker segment walker: directed and random byte streams checked per result.
`timescale 1ns / 100ps

module tb_top;
  import jmsw_pkg::*;

  localparam int STALL_LIMIT  = 500;
  localparam int ITEM_TARGET  = 550;
  localparam int PRINT_LIMIT  = 40;
  localparam int RESULT_BITS  = $bits(result_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic s_tuser = 1'b0;          // [0] start_of_file
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [2:0] event_res, [10:3] marker_code, [18:11] pair_first,
  // [26:19] pair_second, [42:27] segment_length, [47:43] zero
  logic [8*OUT_BYTES-1:0] m_tdata;

  // Walk state of the predictor
  phase_t      walk_phase;
  logic [7:0]  first_byte;
  logic [7:0]  seg_tag;
  logic [7:0]  len_hi;
  logic [15:0] bytes_left;

  result_t pending_results[$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  int walk_items = 0;
  int event_hits[8];
  int stall_cycles = 0;
  bit idle_on = 1'b1;

  jpeg_marker_segment_walker DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tags that open a segment with a length field
  function automatic logic is_segment_tag(input logic [7:0] t);
    case (t)
      TAG_SOI, TAG_EOI, TAG_DQT, TAG_SOF0, TAG_DHT, TAG_SOS: return 1'b1;
      default: return (t >= TAG_APP_LO) && (t <= TAG_APP_HI);
    endcase
  endfunction

  // Advance the predicted walk by one byte and return its result
  function automatic result_t walk_predict(input logic sof, input logic [7:0] b);
    result_t r;
    logic [15:0] full;
    r = '0;
    r.event_res = EV_BUSY;
    full = {len_hi, b};
    if (sof)
      walk_phase = PH_SOI_FIRST;
    case (walk_phase)
      PH_SOI_FIRST: begin
        first_byte = b;
        walk_phase = PH_SOI_SECOND;
      end
      PH_SOI_SECOND: begin
        if (first_byte == MARK_PREFIX && b == TAG_SOI) begin
          r.event_res = EV_START_OK;
          walk_phase = PH_PAIR_FIRST;
        end else begin
          r.event_res = EV_NOT_JPEG;
          r.pair_first = first_byte;
          r.pair_second = b;
          walk_phase = PH_STOPPED;
        end
      end
      PH_PAIR_FIRST: begin
        first_byte = b;
        walk_phase = PH_PAIR_SECOND;
      end
      PH_PAIR_SECOND: begin
        if (first_byte == MARK_PREFIX && is_segment_tag(b)) begin
          seg_tag = b;
          walk_phase = PH_LEN_HIGH;
        end else begin
          r.event_res = EV_STOPPED;
          r.pair_first = first_byte;
          r.pair_second = b;
          walk_phase = PH_STOPPED;
        end
      end
      PH_LEN_HIGH: begin
        len_hi = b;
        walk_phase = PH_LEN_LOW;
      end
      PH_LEN_LOW: begin
        r.marker_code = seg_tag;
        if (full < 16'd2) begin
          r.event_res = EV_BAD_LEN;
          walk_phase = PH_STOPPED;
        end else begin
          r.event_res = EV_SEGMENT;
          r.segment_length = full - 16'd2;
          bytes_left = full - 16'd2;
          walk_phase = (full == 16'd2) ? PH_PAIR_FIRST : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (bytes_left != 16'd0)
          bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0)
          walk_phase = PH_PAIR_FIRST;
      end
      default: begin
        r.event_res = EV_IGNORED;
        walk_phase = PH_STOPPED;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result(input logic [8*OUT_BYTES-1:0] word);
    result_t got;
    result_t want;
    got = result_t'(word[RESULT_BITS-1:0]);
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing expected", word, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.event_res !== want.event_res)
      report_mismatch("event_res", 48'(got.event_res), 48'(want.event_res));
    if (got.marker_code !== want.marker_code)
      report_mismatch("marker_code", 48'(got.marker_code), 48'(want.marker_code));
    if (got.pair_first !== want.pair_first)
      report_mismatch("pair_first", 48'(got.pair_first), 48'(want.pair_first));
    if (got.pair_second !== want.pair_second)
      report_mismatch("pair_second", 48'(got.pair_second), 48'(want.pair_second));
    if (got.segment_length !== want.segment_length)
      report_mismatch("segment_length", 48'(got.segment_length),
                      48'(want.segment_length));
    if (word[8*OUT_BYTES-1:RESULT_BITS] !== '0)
      report_mismatch("tdata padding", 48'(word[8*OUT_BYTES-1:RESULT_BITS]), '0);
  endtask

  // Result side: check each transfer, stall at random while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        check_result(m_tdata);
      m_tready <= idle_on ? ($urandom_range(99) >= 11) : 1'b1;
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, pending_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Send one byte, then record its predicted result
  task automatic send_byte(input logic sof, input logic [7:0] b);
    result_t want;
    while (idle_on && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= sof;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    want = walk_predict(sof, b);
    pending_results.push_back(want);
    event_hits[want.event_res]++;
    bytes_sent++;
    if (want.event_res != EV_IGNORED)
      walk_items++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One file: start bytes, a few segments with random bodies, a random tail
  task automatic send_random_file();
    int seg_total;
    int roll;
    int body_len;
    bit cut_short;
    logic [7:0] tag;
    logic [15:0] seg_len;
    if ($urandom_range(99) < 6) begin
      send_byte(1'b1, 8'($urandom_range(255)));
      send_byte(1'b0, 8'($urandom_range(255)));
    end else begin
      send_byte(1'b1, MARK_PREFIX);
      send_byte(1'b0, TAG_SOI);
    end
    seg_total = $urandom_range(1, 5);
    for (int k = 0; k < seg_total; k++) begin
      // broken pair ends the walk
      if ($urandom_range(99) < 5) begin
        send_byte(1'b0, $urandom_range(1) ? MARK_PREFIX : 8'($urandom_range(255)));
        send_byte(1'b0, 8'($urandom_range(255)));
        break;
      end
      roll = $urandom_range(21);
      if (roll < 16) begin
        tag = TAG_APP_LO + 8'(roll);
      end else begin
        case (roll)
          16: tag = TAG_SOI;
          17: tag = TAG_EOI;
          18: tag = TAG_DQT;
          19: tag = TAG_SOF0;
          20: tag = TAG_DHT;
          default: tag = TAG_SOS;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 5)
        seg_len = 16'($urandom_range(1));
      else if (roll < 8)
        seg_len = 16'($urandom_range(256, 290));
      else
        seg_len = 16'($urandom_range(2, 12));
      send_byte(1'b0, MARK_PREFIX);
      send_byte(1'b0, tag);
      send_byte(1'b0, seg_len[15:8]);
      send_byte(1'b0, seg_len[7:0]);
      if (seg_len < 16'd2)
        break;
      body_len = seg_len - 2;
      cut_short = ($urandom_range(99) < 3);
      if (cut_short)
        body_len = $urandom_range(body_len);
      for (int n = 0; n < body_len; n++)
        send_byte(1'b0, 8'($urandom_range(255)));
      if (cut_short)
        return;
    end
    repeat ($urandom_range(3))
      send_byte(1'b0, 8'($urandom_range(255)));
  endtask

  // First file after reset carries no start mark
  task automatic test_start_without_mark();
    send_byte(1'b0, MARK_PREFIX);
    send_byte(1'b0, TAG_SOI);
    send_byte(1'b0, MARK_PREFIX);
    send_byte(1'b0, TAG_APP_LO);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h03);
    send_byte(1'b0, 8'h5A);
  endtask

  // Zero-length body, largest length abandoned by a start mark, length zero
  task automatic test_length_extremes();
    send_byte(1'b0, MARK_PREFIX);
    send_byte(1'b0, TAG_SOI);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h02);
    send_byte(1'b0, MARK_PREFIX);
    send_byte(1'b0, TAG_SOF0);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, MARK_PREFIX);
    send_byte(1'b0, TAG_SOI);
    send_byte(1'b0, MARK_PREFIX);
    send_byte(1'b0, TAG_EOI);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00);
  endtask

  // Bad start bytes and an unknown tag stop the walk
  task automatic test_stop_and_ignore();
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, MARK_PREFIX);
    send_byte(1'b0, TAG_SOI);
    send_byte(1'b0, MARK_PREFIX);
    send_byte(1'b0, 8'h00);
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (4)
      send_random_file();
    idle_on = 1'b1;
  endtask

  // Random files mixed with noise, with a drain pause now and then
  task automatic test_random_walk();
    int last_pause;
    last_pause = walk_items;
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6))
          send_byte($urandom_range(99) < 15, 8'($urandom_range(255)));
      end else begin
        send_random_file();
      end
      if (walk_items - last_pause > 150) begin
        wait_drained();
        last_pause = walk_items;
      end
    end
  endtask

  initial begin
    walk_phase = PH_SOI_FIRST;
    first_byte = '0;
    seg_tag = '0;
    len_hi = '0;
    bytes_left = '0;
    foreach (event_hits[i])
      event_hits[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_start_without_mark();
    test_length_extremes();
    test_stop_and_ignore();
    wait_drained();
    test_back_to_back();
    wait_drained();
    test_random_walk();
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d bytes; events: %0d start ok, %0d not jpeg, %0d segment,",
             bytes_sent, event_hits[EV_START_OK], event_hits[EV_NOT_JPEG],
             event_hits[EV_SEGMENT]);
    $display("%0d stopped, %0d bad length, %0d ignored, %0d busy; %0d mismatches",
             event_hits[EV_STOPPED], event_hits[EV_BAD_LEN], event_hits[EV_IGNORED],
             event_hits[EV_BUSY], mismatch_count);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
sv/jmsw_pkg.sv
sv/jpeg_marker_segment_walker.sv
verif/tb_top.sv
